// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the wheel speed mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication that is also checked while reset is high.
`define ASSERT_NEXT_NORST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== sv/mwsm_pkg.sv =====
// Package with widths, register indexes and types of the wheel speed mixer.
`timescale 1ns / 1ps
package mwsm_pkg;
   localparam int IN_W      = 16;
   localparam int GAIN_W    = 32;
   localparam int LIM_W     = 23;
   localparam int WHEEL_W   = 24;
   localparam int FRAC_DROP = 20;
   localparam int PROD_W    = IN_W + GAIN_W;
   localparam int TERM_W    = PROD_W + 1 - FRAC_DROP;
   localparam int SUM_W     = 31;
   localparam int ABS_W     = SUM_W - 1;
   localparam int NUM_W     = ABS_W + LIM_W + 1;
   localparam int DEN_W     = ABS_W + 1;
   localparam int QUO_W     = LIM_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int LANES     = 4;
   localparam int NSTG      = 4 + QUO_W + 1;

   localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(65536);
   localparam logic [LIM_W-1:0]  LIMIT_RESET = {LIM_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRANSLATION_GAIN  = 2'd0,
      CSR_ROTATION_GAIN     = 2'd1,
      CSR_WHEEL_SPEED_LIMIT = 2'd2
   } csr_index_type;
endpackage

// ===== sv/mwsm_ifs.sv =====
// Valid/ready channel interfaces for commands and wheel speed results.
`timescale 1ns / 1ps
interface mwsm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mwsm_pkg::IN_W-1:0]    forward_velocity;
   logic signed [mwsm_pkg::IN_W-1:0]    lateral_velocity;
   logic signed [mwsm_pkg::IN_W-1:0]    yaw_rate;
   modport source (output valid, forward_velocity, lateral_velocity, yaw_rate, input ready);
   modport sink (input valid, forward_velocity, lateral_velocity, yaw_rate, output ready);
endinterface

interface mwsm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_front_right;
   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_front_left;
   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_rear_left;
   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_rear_right;
   logic                                was_scaled;
   modport source (output valid, wheel_front_right, wheel_front_left, wheel_rear_left,
                   wheel_rear_right, was_scaled, input ready);
   modport sink (input valid, wheel_front_right, wheel_front_left, wheel_rear_left,
                 wheel_rear_right, was_scaled, output ready);
endinterface

// ===== sv/mecanum_wheel_speed_mixer.sv =====
// Top level of the mecanum wheel speed mixer with peak normalization.
// The pipeline runs from command transfer to result valid through 4 mix stages,
// 23 restoring divider stages and one output register.
// Throughput: one command per cycle while results are taken; a full stage holds while the one after it cannot advance.
// Reset clears all valid bits and loads gains of 65536 and the largest limit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mecanum_wheel_speed_mixer (
   input  logic                                clock,
   input  logic                                reset,
   mwsm_req_if.sink                            req_bus,
   mwsm_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_en,
   input  logic [mwsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mwsm_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   localparam int NS = mwsm_pkg::NSTG;
   localparam int QW = mwsm_pkg::QUO_W;
   localparam int NL = mwsm_pkg::LANES;
   localparam int DIV0 = 4;

   logic [mwsm_pkg::GAIN_W-1:0] trans_gain_ff;
   logic [mwsm_pkg::GAIN_W-1:0] rot_gain_ff;
   logic [mwsm_pkg::LIM_W-1:0]  limit_ff;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] adv;

   logic [mwsm_pkg::PROD_W-1:0]        prod_ff [3];
   logic [2:0]                         pneg_ff;
   logic signed [mwsm_pkg::SUM_W-1:0]  sum_ff [NL];
   logic [mwsm_pkg::ABS_W-1:0]         abs_ff [NL];
   logic [NL-1:0]                      aneg_ff;
   logic [mwsm_pkg::ABS_W-1:0]         peak_ff;
   logic                               ascl_ff;

   logic [mwsm_pkg::NUM_W-1:0]   rem_ff [QW][NL];
   logic [QW-1:0]                quo_ff [QW+1][NL];
   logic [mwsm_pkg::DEN_W-1:0]   den_ff [QW];
   logic [NL-1:0]                neg_ff [QW+1];
   logic [mwsm_pkg::ABS_W-1:0]   mag_ff [QW+1][NL];
   logic                         scl_ff [QW+1];

   logic [mwsm_pkg::NUM_W-1:0]   rem_in [QW][NL];
   logic                         bit_in [QW][NL];

   logic signed [mwsm_pkg::WHEEL_W-1:0] wheel_ff [NL];
   logic                                wscl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_gain_ff <= mwsm_pkg::GAIN_RESET;
         rot_gain_ff   <= mwsm_pkg::GAIN_RESET;
         limit_ff      <= mwsm_pkg::LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (mwsm_pkg::csr_index_type'(csr_index))
            mwsm_pkg::CSR_TRANSLATION_GAIN: trans_gain_ff <= csr_wdata;
            mwsm_pkg::CSR_ROTATION_GAIN:    rot_gain_ff   <= csr_wdata;
            mwsm_pkg::CSR_WHEEL_SPEED_LIMIT: limit_ff <= csr_wdata[mwsm_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || rsp_bus.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign req_bus.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_bus.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Stage 1: magnitude times gain.
   logic signed [mwsm_pkg::IN_W-1:0] in_val [3];
   logic [mwsm_pkg::IN_W-1:0]        in_mag [3];
   logic [mwsm_pkg::GAIN_W-1:0]      in_gain [3];

   always_comb begin
      in_val[0]  = req_bus.forward_velocity;
      in_val[1]  = req_bus.lateral_velocity;
      in_val[2]  = req_bus.yaw_rate;
      in_gain[0] = trans_gain_ff;
      in_gain[1] = trans_gain_ff;
      in_gain[2] = rot_gain_ff;
      for (int j = 0; j < 3; j++) begin
         in_mag[j] = in_val[j][mwsm_pkg::IN_W-1] ? (-in_val[j]) : in_val[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[j] <= mwsm_pkg::PROD_W'(in_mag[j]) * mwsm_pkg::PROD_W'(in_gain[j]);
            pneg_ff[j] <= in_val[j][mwsm_pkg::IN_W-1];
         end
      end
   end

   // Stage 2: rounding and mixing.
   logic [mwsm_pkg::PROD_W:0]          rnd [3];
   logic signed [mwsm_pkg::SUM_W-1:0]  term [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         rnd[j] = {1'b0, prod_ff[j]} + (mwsm_pkg::PROD_W+1)'(1 << (mwsm_pkg::FRAC_DROP - 1));
         term[j] = mwsm_pkg::SUM_W'(rnd[j][mwsm_pkg::FRAC_DROP +: mwsm_pkg::TERM_W]);
         if (pneg_ff[j]) begin
            term[j] = -term[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sum_ff[0] <= -term[0] - term[1] + term[2];
         sum_ff[1] <=  term[0] - term[1] + term[2];
         sum_ff[2] <=  term[0] + term[1] + term[2];
         sum_ff[3] <= -term[0] + term[1] + term[2];
      end
   end

   // Stage 3: absolute values and peak.
   logic [mwsm_pkg::ABS_W-1:0] w_abs [NL];
   logic [mwsm_pkg::ABS_W-1:0] pk_a;
   logic [mwsm_pkg::ABS_W-1:0] pk_b;
   logic [mwsm_pkg::ABS_W-1:0] pk;
   logic signed [mwsm_pkg::SUM_W-1:0] w_neg [NL];

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         w_neg[l] = -sum_ff[l];
         w_abs[l] = sum_ff[l][mwsm_pkg::SUM_W-1] ? w_neg[l][mwsm_pkg::ABS_W-1:0]
                                                 : sum_ff[l][mwsm_pkg::ABS_W-1:0];
      end
      pk_a = (w_abs[0] > w_abs[1]) ? w_abs[0] : w_abs[1];
      pk_b = (w_abs[2] > w_abs[3]) ? w_abs[2] : w_abs[3];
      pk   = (pk_a > pk_b) ? pk_a : pk_b;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int l = 0; l < NL; l++) begin
            abs_ff[l]  <= w_abs[l];
            aneg_ff[l] <= sum_ff[l][mwsm_pkg::SUM_W-1];
         end
         peak_ff <= pk;
         ascl_ff <= pk > mwsm_pkg::ABS_W'(limit_ff);
      end
   end

   // The peak is added after the shift so that the product stays in the multiplier stage.
   logic [mwsm_pkg::NUM_W-1:0] rem_first [NL];

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         rem_first[l] = rem_ff[0][l] + mwsm_pkg::NUM_W'(den_ff[0][mwsm_pkg::DEN_W-1:1]);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      for (genvar l = 0; l < NL; l++) begin : g_lane
         mwsm_div_step #(
            .SHIFT(QW - 1 - k)
         ) u_step (
            .rem_i ((k == 0) ? rem_first[l] : rem_ff[k][l]),
            .den_i (den_ff[k]),
            .rem_o (rem_in[k][l]),
            .bit_o (bit_in[k][l])
         );
      end
   end

   // Stage 4: numerator 2*|w|*limit + peak and denominator 2*peak, then the divider stages.
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int l = 0; l < NL; l++) begin
            rem_ff[0][l] <= {mwsm_pkg::NUM_W'(abs_ff[l]) * mwsm_pkg::NUM_W'(limit_ff)} << 1
                            | mwsm_pkg::NUM_W'(0);
            quo_ff[0][l] <= '0;
            mag_ff[0][l] <= abs_ff[l];
         end
         den_ff[0] <= {peak_ff, 1'b0};
         neg_ff[0] <= aneg_ff;
         scl_ff[0] <= ascl_ff;
      end
      for (int k = 0; k < QW - 1; k++) begin
         if (adv[DIV0 + k]) begin
            for (int l = 0; l < NL; l++) begin
               rem_ff[k+1][l] <= rem_in[k][l];
            end
            den_ff[k+1] <= den_ff[k];
         end
      end
      for (int k = 0; k < QW; k++) begin
         if (adv[DIV0 + k]) begin
            for (int l = 0; l < NL; l++) begin
               quo_ff[k+1][l] <= {quo_ff[k][l][QW-2:0], bit_in[k][l]};
               mag_ff[k+1][l] <= mag_ff[k][l];
            end
            neg_ff[k+1] <= neg_ff[k];
            scl_ff[k+1] <= scl_ff[k];
         end
      end
   end

   // Output register: sign, select and clamp.
   logic [mwsm_pkg::ABS_W-1:0]          fin_mag [NL];
   logic signed [mwsm_pkg::WHEEL_W-1:0] fin_val [NL];

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         fin_mag[l] = scl_ff[QW] ? mwsm_pkg::ABS_W'(quo_ff[QW][l]) : mag_ff[QW][l];
         if (!neg_ff[QW][l]) begin
            if (fin_mag[l] > mwsm_pkg::ABS_W'({1'b0, {(mwsm_pkg::WHEEL_W-1){1'b1}}})) begin
               fin_val[l] = {1'b0, {(mwsm_pkg::WHEEL_W-1){1'b1}}};
            end else begin
               fin_val[l] = fin_mag[l][mwsm_pkg::WHEEL_W-1:0];
            end
         end else begin
            if (fin_mag[l] > mwsm_pkg::ABS_W'({1'b1, {(mwsm_pkg::WHEEL_W-1){1'b0}}})) begin
               fin_val[l] = {1'b1, {(mwsm_pkg::WHEEL_W-1){1'b0}}};
            end else begin
               fin_val[l] = -fin_mag[l][mwsm_pkg::WHEEL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         for (int l = 0; l < NL; l++) begin
            wheel_ff[l] <= fin_val[l];
         end
         wscl_ff <= scl_ff[QW];
      end
   end

   assign rsp_bus.valid             = v_ff[NS-1];
   assign rsp_bus.wheel_front_right = wheel_ff[0];
   assign rsp_bus.wheel_front_left  = wheel_ff[1];
   assign rsp_bus.wheel_rear_left   = wheel_ff[2];
   assign rsp_bus.wheel_rear_right  = wheel_ff[3];
   assign rsp_bus.was_scaled        = wscl_ff;

   logic [mwsm_pkg::WHEEL_W-1:0] chk_mag [NL];
   logic [mwsm_pkg::WHEEL_W-1:0] chk_lim;

   always_comb begin
      chk_lim = mwsm_pkg::WHEEL_W'(limit_ff);
      for (int l = 0; l < NL; l++) begin
         chk_mag[l] = wheel_ff[l][mwsm_pkg::WHEEL_W-1] ? (-wheel_ff[l]) : wheel_ff[l];
      end
   end

   `ASSERT_IMPLY(a_within_limit, clock, reset, rsp_bus.valid,
      chk_mag[0] <= chk_lim && chk_mag[1] <= chk_lim &&
      chk_mag[2] <= chk_lim && chk_mag[3] <= chk_lim)
   `ASSERT_IMPLY(a_zero_limit, clock, reset, rsp_bus.valid && rsp_bus.was_scaled && limit_ff == '0,
      wheel_ff[0] == '0 && wheel_ff[1] == '0 && wheel_ff[2] == '0 && wheel_ff[3] == '0)
   `ASSERT_NEXT_NORST(a_reset_empty, clock, reset, v_ff == '0)
endmodule

// ===== sv/mwsm_div_step.sv =====
// One restoring division step at a fixed quotient bit position.
`timescale 1ns / 1ps
module mwsm_div_step #(
   parameter int SHIFT = 0
) (
   input  logic [mwsm_pkg::NUM_W-1:0] rem_i,
   input  logic [mwsm_pkg::DEN_W-1:0] den_i,
   output logic [mwsm_pkg::NUM_W-1:0] rem_o,
   output logic                       bit_o
);
   logic [mwsm_pkg::NUM_W-1:0] den_sh;

   always_comb begin
      den_sh = mwsm_pkg::NUM_W'(den_i) << SHIFT;
      bit_o  = (rem_i >= den_sh);
      rem_o  = bit_o ? (rem_i - den_sh) : rem_i;
   end
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the mecanum wheel speed mixer with random traffic and stalls.
`timescale 1ns / 1ps
module tb_top;
   localparam logic [mwsm_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [mwsm_pkg::WHEEL_W-1:0] wheel[mwsm_pkg::LANES];
      logic                                scaled;
   } wheel_set_type;

   class wheel_scoreboard;
      logic [mwsm_pkg::GAIN_W-1:0] trans_gain;
      logic [mwsm_pkg::GAIN_W-1:0] rot_gain;
      logic [mwsm_pkg::LIM_W-1:0]  limit;
      wheel_set_type               pending_wheels[$];
      int                          errors;

      function new();
         trans_gain = mwsm_pkg::GAIN_RESET;
         rot_gain = mwsm_pkg::GAIN_RESET;
         limit = mwsm_pkg::LIMIT_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [mwsm_pkg::CSR_IDX_W-1:0] idx,
                              logic [mwsm_pkg::CSR_DAT_W-1:0] val);
         case (idx)
            mwsm_pkg::CSR_TRANSLATION_GAIN: begin
               trans_gain = val;
            end
            mwsm_pkg::CSR_ROTATION_GAIN: begin
               rot_gain = val;
            end
            mwsm_pkg::CSR_WHEEL_SPEED_LIMIT: begin
               limit = val[mwsm_pkg::LIM_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function longint round_term(logic signed [mwsm_pkg::IN_W-1:0] v,
                                  logic [mwsm_pkg::GAIN_W-1:0] gain);
         longint unsigned mag;
         longint unsigned prod;
         mag = (v < 0) ? longint'(-longint'(v)) : longint'(v);
         prod = (mag * longint'(gain) + (64'd1 << (mwsm_pkg::FRAC_DROP - 1)))
                >> mwsm_pkg::FRAC_DROP;
         return (v < 0) ? -longint'(prod) : longint'(prod);
      endfunction

      function void note_command(logic signed [mwsm_pkg::IN_W-1:0] fwd,
                                 logic signed [mwsm_pkg::IN_W-1:0] lat,
                                 logic signed [mwsm_pkg::IN_W-1:0] yaw);
         longint x, y, z, v;
         longint s[mwsm_pkg::LANES];
         longint unsigned peak, mag, q;
         wheel_set_type e;
         x = round_term(fwd, trans_gain);
         y = round_term(lat, trans_gain);
         z = round_term(yaw, rot_gain);
         s[0] = -x - y + z;
         s[1] = x - y + z;
         s[2] = x + y + z;
         s[3] = -x + y + z;
         peak = 0;
         for (int i = 0; i < mwsm_pkg::LANES; i++) begin
            mag = (s[i] < 0) ? -s[i] : s[i];
            if (mag > peak) peak = mag;
         end
         e.scaled = peak > longint'(limit);
         for (int i = 0; i < mwsm_pkg::LANES; i++) begin
            v = s[i];
            if (e.scaled) begin
               mag = (v < 0) ? -v : v;
               q = (mag * longint'(limit) * 2 + peak) / (peak * 2);
               v = (v < 0) ? -longint'(q) : longint'(q);
            end
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            e.wheel[i] = v[mwsm_pkg::WHEEL_W-1:0];
         end
         pending_wheels.push_back(e);
      endfunction

      function void check_wheels(wheel_set_type got);
         wheel_set_type e;
         string names[mwsm_pkg::LANES] = '{"wheel_front_right", "wheel_front_left",
                                           "wheel_rear_left", "wheel_rear_right"};
         if (pending_wheels.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         e = pending_wheels.pop_front();
         for (int i = 0; i < mwsm_pkg::LANES; i++) begin
            if (got.wheel[i] !== e.wheel[i]) begin
               $error("%s expected %0d actual %0d", names[i], e.wheel[i], got.wheel[i]);
               errors++;
            end
         end
         if (got.scaled !== e.scaled) begin
            $error("was_scaled expected %0d actual %0d", e.scaled, got.scaled);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [mwsm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mwsm_pkg::CSR_DAT_W-1:0] csr_wdata;
   bit steady;
   bit hold_request;
   int cycles = 0;
   wheel_scoreboard board;

   mwsm_req_if req_bus();
   mwsm_rsp_if rsp_bus();

   mecanum_wheel_speed_mixer dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         board.note_command(req_bus.forward_velocity, req_bus.lateral_velocity,
                            req_bus.yaw_rate);
   end

   // The receiver owns the long hold-off counter.
   int hold_left = 0;
   bit hold_seen = 0;
   always @(posedge clock) begin
      wheel_set_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.wheel[0] = rsp_bus.wheel_front_right;
         got.wheel[1] = rsp_bus.wheel_front_left;
         got.wheel[2] = rsp_bus.wheel_rear_left;
         got.wheel[3] = rsp_bus.wheel_rear_right;
         got.scaled = rsp_bus.was_scaled;
         board.check_wheels(got);
      end
      if (hold_request && !hold_seen) hold_left = 400;
      hold_seen = hold_request;
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 19);
      end
   end

   function automatic logic signed [mwsm_pkg::IN_W-1:0] pick_velocity();
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return mwsm_pkg::IN_W'($urandom_range(0, 64)) - 16'sd32;
         default: return mwsm_pkg::IN_W'($urandom);
      endcase
   endfunction

   task automatic send_command(logic signed [mwsm_pkg::IN_W-1:0] fwd,
                               logic signed [mwsm_pkg::IN_W-1:0] lat,
                               logic signed [mwsm_pkg::IN_W-1:0] yaw);
      while (!steady && $urandom_range(0, 99) < 19) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.forward_velocity <= fwd;
      req_bus.lateral_velocity <= lat;
      req_bus.yaw_rate <= yaw;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_wheels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [mwsm_pkg::CSR_IDX_W-1:0] idx,
                            logic [mwsm_pkg::CSR_DAT_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++)
         send_command(pick_velocity(), pick_velocity(), pick_velocity());
   endtask

   initial begin
      logic signed [mwsm_pkg::IN_W-1:0] corner[4] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
      req_bus.valid = 1'b0;
      req_bus.forward_velocity = '0;
      req_bus.lateral_velocity = '0;
      req_bus.yaw_rate = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      @(negedge reset);
      @(posedge clock);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            send_command(corner[i], corner[j], corner[(i + j) % 4]);
      send_command(16'sd1, 16'sd0, 16'sd0);
      send_command(16'sd0, 16'sd0, 16'sd1);
      run_random(120);
      drain();

      write_csr(mwsm_pkg::CSR_TRANSLATION_GAIN, 32'hFFFF_FFFF);
      write_csr(mwsm_pkg::CSR_ROTATION_GAIN, 32'hFFFF_FFFF);
      write_csr(mwsm_pkg::CSR_WHEEL_SPEED_LIMIT, 32'd1000);
      send_command(-16'sd32768, -16'sd32768, 16'sd32767);
      send_command(16'sd0, 16'sd0, 16'sd0);
      run_random(150);
      drain();

      write_csr(mwsm_pkg::CSR_WHEEL_SPEED_LIMIT, 32'd0);
      write_csr(mwsm_pkg::CSR_TRANSLATION_GAIN, 32'd0);
      send_command(16'sd0, 16'sd0, 16'sd0);
      send_command(16'sd32767, 16'sd5, -16'sd32768);
      run_random(120);
      drain();

      write_csr(CSR_UNUSED_INDEX, 32'h1234_5678);
      write_csr(mwsm_pkg::CSR_ROTATION_GAIN, 32'd0);
      write_csr(mwsm_pkg::CSR_TRANSLATION_GAIN, 32'h0001_8000);
      write_csr(mwsm_pkg::CSR_WHEEL_SPEED_LIMIT, 32'hFFFF_FFFF);
      steady = 1'b1;
      hold_request = 1'b1;
      run_random(200);
      hold_request = 1'b0;
      steady = 1'b0;
      drain();

      for (int p = 0; p < 6; p++) begin
         write_csr(mwsm_pkg::CSR_TRANSLATION_GAIN, $urandom);
         write_csr(mwsm_pkg::CSR_ROTATION_GAIN,
                   ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 1 << 20));
         write_csr(mwsm_pkg::CSR_WHEEL_SPEED_LIMIT,
                   ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 5000));
         run_random(125);
         drain();
      end

      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
